@@ rtl/core/hre_pkg.sv @@
// Shared constants, item types and view pair tables for the homography
// reprojection error unit. No dependencies.
package hre_pkg;

    localparam int NUM_HOMOGRAPHIES  = 4;
    localparam int COEFFS_PER_MATRIX = 9;
    localparam int NUM_PAIRS         = 10;
    localparam int QUOT_W            = 27;
    localparam int DIV_STEPS         = 27;
    localparam int ROOT_STEPS        = 28;
    localparam int ROOT_W            = 57;

    localparam logic ACTION_LOAD    = 1'b0;
    localparam logic ACTION_MEASURE = 1'b1;

    localparam logic [23:0] ERR_MAX = 24'hFF_FFFF;
    localparam logic [63:0] W_ONE   = 64'h0000_0001_0000_0000;

    // Beat travelling through the homography chain; loads ride along too
    typedef struct packed {
        logic               is_load;
        logic [5:0]         coeff_index;
        logic signed [47:0] coeff_value;
        logic [2:0]         pair_from;
        logic [2:0]         pair_to;
        logic signed [63:0] vx;
        logic signed [63:0] vy;
        logic signed [63:0] vw;
        logic               ovf;
        logic [23:0]        dst_x;
        logic [23:0]        dst_y;
    } hre_item_t;

    // Beat inside the divider
    typedef struct packed {
        logic              err;
        logic              neg_x;
        logic              neg_y;
        logic [71:0]       rx;
        logic [71:0]       ry;
        logic [63:0]       d;
        logic [QUOT_W-1:0] qx;
        logic [QUOT_W-1:0] qy;
        logic [23:0]       dst_x;
        logic [23:0]       dst_y;
    } hre_div_t;

    // Beat inside the square root
    typedef struct packed {
        logic              err;
        logic [ROOT_W-1:0] n;
        logic [ROOT_W-1:0] res;
    } hre_root_t;

    function automatic logic [2:0] pair_from_f(input logic [3:0] pair);
        logic [2:0] v;
        case (pair)
            4'd0, 4'd1, 4'd2, 4'd3: v = 3'd0;
            4'd4, 4'd5, 4'd6:       v = 3'd1;
            4'd7, 4'd8:             v = 3'd2;
            4'd9:                   v = 3'd3;
            default:                v = 3'd0;
        endcase
        return v;
    endfunction

    function automatic logic [2:0] pair_to_f(input logic [3:0] pair);
        logic [2:0] v;
        case (pair)
            4'd0:                   v = 3'd1;
            4'd1, 4'd4:             v = 3'd2;
            4'd2, 4'd5, 4'd7:       v = 3'd3;
            4'd3, 4'd6, 4'd8, 4'd9: v = 3'd4;
            default:                v = 3'd0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/core/hre_if.sv @@
// Valid/ready channel interfaces for the item and result streams.
// No dependencies.
interface hre_item_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic [5:0]         coeff_index;
    logic signed [47:0] coeff_value;
    logic [3:0]         pair_index;
    logic [23:0]        src_x;
    logic [23:0]        src_y;
    logic [23:0]        dst_x;
    logic [23:0]        dst_y;

    modport source (output valid, action, coeff_index, coeff_value, pair_index,
                    src_x, src_y, dst_x, dst_y, input ready);
    modport sink (input valid, action, coeff_index, coeff_value, pair_index,
                  src_x, src_y, dst_x, dst_y, output ready);
endinterface

interface hre_result_if;
    logic        valid;
    logic        ready;
    logic [23:0] reproj_error;
    logic        degenerate;

    modport source (output valid, reproj_error, degenerate, input ready);
    modport sink (input valid, reproj_error, degenerate, output ready);
endinterface

@@ rtl/core/homography_reprojection_error_unit.sv @@
// Homography reprojection error unit: entry register, homography chain,
// divider, distance pipeline and output register.
// Throughput: one beat per cycle; the whole pipeline holds while a result waits.
// Reset clears all valid bits; coefficients are undefined until loaded.
module homography_reprojection_error_unit (
    input  logic clk,
    input  logic rst_n,
    hre_item_if.sink     item,
    hre_result_if.source result
);
    import hre_pkg::*;

    logic advance;
    logic accept;
    logic measure_ok;
    logic entry_valid;
    hre_item_t entry_item;
    logic [2:0] pf;
    logic [2:0] pt;

    logic      s0_valid_reg;
    hre_item_t s0_item_reg;

    logic      mat_valid [NUM_HOMOGRAPHIES+1];
    hre_item_t mat_item  [NUM_HOMOGRAPHIES+1];

    logic     div_valid;
    hre_div_t div_out;
    logic        dist_valid;
    logic [23:0] dist_error;
    logic        dist_degenerate;

    logic        out_valid_reg;
    logic [23:0] out_error_reg;
    logic        out_degenerate_reg;

    // Hold the pipeline while a result waits
    assign advance    = !out_valid_reg || result.ready;
    assign item.ready = advance;
    assign accept     = item.valid && advance;

    // Build the entry beat; drop measures on pairs out of range
    always_comb
    begin
        pf = pair_from_f(item.pair_index);
        pt = pair_to_f(item.pair_index);
        measure_ok  = (item.pair_index inside {[4'd0:4'd9]})
                      && ({1'b0, pt} <= 4'(NUM_HOMOGRAPHIES));
        entry_valid = accept && ((item.action == ACTION_LOAD) || measure_ok);
        entry_item.is_load     = (item.action == ACTION_LOAD);
        entry_item.coeff_index = item.coeff_index;
        entry_item.coeff_value = item.coeff_value;
        entry_item.pair_from   = pf;
        entry_item.pair_to     = pt;
        entry_item.vx          = $signed({16'b0, item.src_x, 24'b0});
        entry_item.vy          = $signed({16'b0, item.src_y, 24'b0});
        entry_item.vw          = $signed(W_ONE);
        entry_item.ovf         = 1'b0;
        entry_item.dst_x       = item.dst_x;
        entry_item.dst_y       = item.dst_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s0_valid_reg <= entry_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s0_item_reg <= entry_item;
        end
    end

    assign mat_valid[0] = s0_valid_reg;
    assign mat_item[0]  = s0_item_reg;

    // Homography chain
    for (genvar g = 0; g < NUM_HOMOGRAPHIES; g++)
    begin : g_mat
        hre_matrix_stage u_mat (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .matrix_id (3'(g)),
            .in_valid  (mat_valid[g]),
            .in_item   (mat_item[g]),
            .out_valid (mat_valid[g+1]),
            .out_item  (mat_item[g+1])
        );
    end

    // Loads end at the chain
    hre_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (mat_valid[NUM_HOMOGRAPHIES] && !mat_item[NUM_HOMOGRAPHIES].is_load),
        .in_item   (mat_item[NUM_HOMOGRAPHIES]),
        .out_valid (div_valid),
        .out_div   (div_out)
    );

    hre_distance u_dist (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .in_valid     (div_valid),
        .in_div       (div_out),
        .out_valid    (dist_valid),
        .reproj_error (dist_error),
        .degenerate   (dist_degenerate)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= dist_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_error_reg      <= dist_error;
            out_degenerate_reg <= dist_degenerate;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.reproj_error = out_error_reg;
    assign result.degenerate   = out_degenerate_reg;

    // A flagged result always carries the saturated code
    a_degenerate_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_degenerate_reg |-> out_error_reg == ERR_MAX)
        else $error("degenerate result without saturated error");

    // Only measures on a reachable pair enter the chain
    a_pair_range: assert property (@(posedge clk) disable iff (!rst_n)
        s0_valid_reg && !s0_item_reg.is_load |->
            (s0_item_reg.pair_from < s0_item_reg.pair_to)
            && ({1'b0, s0_item_reg.pair_to} <= 4'(NUM_HOMOGRAPHIES)))
        else $error("measure on unreachable pair entered the chain");

    // A stalled output keeps its beat
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result.ready |=> out_valid_reg && $stable(out_error_reg))
        else $error("result beat lost during stall");

endmodule

@@ rtl/core/hre_matrix_stage.sv @@
// One homography of the chain: coefficient registers plus a three stage
// multiply, floor and row sum datapath. Depends on hre_pkg.
module hre_matrix_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic [2:0]        matrix_id,
    input  logic              in_valid,
    input  hre_pkg::hre_item_t in_item,
    output logic              out_valid,
    output hre_pkg::hre_item_t out_item
);
    import hre_pkg::*;

    logic signed [47:0] coeff_reg [COEFFS_PER_MATRIX];

    logic [6:0] base;
    logic [6:0] slot_wide;
    logic       hit;
    logic       active;
    logic signed [63:0] comp [3];

    logic [63:0]        ll_next [COEFFS_PER_MATRIX];
    logic signed [64:0] lh_next [COEFFS_PER_MATRIX];
    logic signed [48:0] hl_next [COEFFS_PER_MATRIX];
    logic signed [47:0] hh_next [COEFFS_PER_MATRIX];
    logic [63:0]        ll_reg  [COEFFS_PER_MATRIX];
    logic signed [64:0] lh_reg  [COEFFS_PER_MATRIX];
    logic signed [48:0] hl_reg  [COEFFS_PER_MATRIX];
    logic signed [47:0] hh_reg  [COEFFS_PER_MATRIX];
    logic               a_valid_reg;
    logic               a_active_reg;
    hre_item_t          a_item_reg;

    logic [63:0] prod_next [COEFFS_PER_MATRIX];
    logic        povf_next [COEFFS_PER_MATRIX];
    logic [63:0] prod_reg  [COEFFS_PER_MATRIX];
    logic        povf_reg  [COEFFS_PER_MATRIX];
    logic        b_valid_reg;
    logic        b_active_reg;
    hre_item_t   b_item_reg;

    logic        c_valid_reg;
    hre_item_t   c_item_reg;
    hre_item_t   c_item_next;

    // Decode a load for this matrix
    always_comb
    begin
        base      = 7'(matrix_id) * 7'(COEFFS_PER_MATRIX);
        slot_wide = {1'b0, in_item.coeff_index} - base;
        hit       = ({1'b0, in_item.coeff_index} >= base)
                    && (slot_wide < 7'(COEFFS_PER_MATRIX));
        active    = !in_item.is_load && (matrix_id >= in_item.pair_from)
                    && (matrix_id < in_item.pair_to);
    end

    // Write the coefficient as the load beat passes
    always_ff @(posedge clk)
    begin
        if (advance && in_valid && in_item.is_load && hit)
        begin
            coeff_reg[slot_wide[3:0]] <= in_item.coeff_value;
        end
    end

    // Partial products, each at most 33 by 33 bits
    always_comb
    begin
        comp[0] = in_item.vx;
        comp[1] = in_item.vy;
        comp[2] = in_item.vw;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                ll_next[r*3+c] = {32'b0, coeff_reg[r*3+c][31:0]} * {32'b0, comp[c][31:0]};
                lh_next[r*3+c] = $signed({1'b0, coeff_reg[r*3+c][31:0]})
                                 * $signed(comp[c][63:32]);
                hl_next[r*3+c] = $signed(coeff_reg[r*3+c][47:32])
                                 * $signed({1'b0, comp[c][31:0]});
                hh_next[r*3+c] = $signed(coeff_reg[r*3+c][47:32])
                                 * $signed(comp[c][63:32]);
            end
        end
    end

    // Assemble each product, floor by 2^32 and check the 64-bit range
    always_comb
    begin
        logic [111:0] mid;
        logic [111:0] p;
        for (int e = 0; e < COEFFS_PER_MATRIX; e++)
        begin
            mid = {{47{lh_reg[e][64]}}, lh_reg[e]} + {{63{hl_reg[e][48]}}, hl_reg[e]};
            p   = {hh_reg[e], 64'b0} + (mid << 32) + {48'b0, ll_reg[e]};
            prod_next[e] = p[95:32];
            povf_next[e] = !((p[111:95] == '0) || (p[111:95] == '1));
        end
    end

    // Row sums with overflow checks; bypass when the matrix is not on the path
    always_comb
    begin
        logic [64:0] s1;
        logic [64:0] s2;
        logic        o;
        logic [63:0] nv [3];
        o = 1'b0;
        for (int r = 0; r < 3; r++)
        begin
            s1 = {prod_reg[r*3][63], prod_reg[r*3]}
                 + {prod_reg[r*3+1][63], prod_reg[r*3+1]};
            s2 = {s1[63], s1[63:0]} + {prod_reg[r*3+2][63], prod_reg[r*3+2]};
            o  = o | (s1[64] ^ s1[63]) | (s2[64] ^ s2[63])
                 | povf_reg[r*3] | povf_reg[r*3+1] | povf_reg[r*3+2];
            nv[r] = s2[63:0];
        end
        c_item_next = b_item_reg;
        if (b_active_reg)
        begin
            c_item_next.vx  = $signed(nv[0]);
            c_item_next.vy  = $signed(nv[1]);
            c_item_next.vw  = $signed(nv[2]);
            c_item_next.ovf = b_item_reg.ovf | o;
        end
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ll_reg       <= ll_next;
            lh_reg       <= lh_next;
            hl_reg       <= hl_next;
            hh_reg       <= hh_next;
            a_active_reg <= active;
            a_item_reg   <= in_item;
            prod_reg     <= prod_next;
            povf_reg     <= povf_next;
            b_active_reg <= a_active_reg;
            b_item_reg   <= a_item_reg;
            c_item_reg   <= c_item_next;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_item  = c_item_reg;

endmodule

@@ rtl/core/hre_divider.sv @@
// Pipelined restoring divider: X/W and Y/W in Q.8, one quotient bit per
// stage for both coordinates. Depends on hre_pkg.
module hre_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              in_valid,
    input  hre_pkg::hre_item_t in_item,
    output logic              out_valid,
    output hre_pkg::hre_div_t  out_div
);
    import hre_pkg::*;

    logic     valid_reg [DIV_STEPS+1];
    hre_div_t stage_reg [DIV_STEPS+1];
    hre_div_t stage_next [DIV_STEPS+1];

    // Magnitudes, signs and the early range check, then one quotient bit
    // per stage, most significant first
    always_comb
    begin
        logic [63:0] nx;
        logic [63:0] ny;
        logic [63:0] d;
        logic [90:0] dsh;
        logic [90:0] r91;
        nx = in_item.vx[63] ? 64'(-in_item.vx) : in_item.vx;
        ny = in_item.vy[63] ? 64'(-in_item.vy) : in_item.vy;
        d  = in_item.vw[63] ? 64'(-in_item.vw) : in_item.vw;
        stage_next[0].err   = in_item.ovf || (d == 64'b0)
                              || ({19'b0, nx} >= {d, 19'b0})
                              || ({19'b0, ny} >= {d, 19'b0});
        stage_next[0].neg_x = in_item.vx[63] ^ in_item.vw[63];
        stage_next[0].neg_y = in_item.vy[63] ^ in_item.vw[63];
        stage_next[0].rx    = {nx, 8'b0};
        stage_next[0].ry    = {ny, 8'b0};
        stage_next[0].d     = d;
        stage_next[0].qx    = '0;
        stage_next[0].qy    = '0;
        stage_next[0].dst_x = in_item.dst_x;
        stage_next[0].dst_y = in_item.dst_y;
        for (int g = 0; g < DIV_STEPS; g++)
        begin
            stage_next[g+1] = stage_reg[g];
            dsh = {27'b0, stage_reg[g].d} << (DIV_STEPS - 1 - g);
            r91 = {19'b0, stage_reg[g].rx};
            if (r91 >= dsh)
            begin
                stage_next[g+1].rx = 72'(r91 - dsh);
                stage_next[g+1].qx = stage_reg[g].qx
                                     | (QUOT_W'(1) << (DIV_STEPS - 1 - g));
            end
            r91 = {19'b0, stage_reg[g].ry};
            if (r91 >= dsh)
            begin
                stage_next[g+1].ry = 72'(r91 - dsh);
                stage_next[g+1].qy = stage_reg[g].qy
                                     | (QUOT_W'(1) << (DIV_STEPS - 1 - g));
            end
        end
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g <= DIV_STEPS; g++)
            begin
                valid_reg[g] <= 1'b0;
            end
        end
        else if (advance)
        begin
            valid_reg[0] <= in_valid;
            for (int g = 0; g < DIV_STEPS; g++)
            begin
                valid_reg[g+1] <= valid_reg[g];
            end
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            stage_reg <= stage_next;
        end
    end

    assign out_valid = valid_reg[DIV_STEPS];
    assign out_div   = stage_reg[DIV_STEPS];

endmodule

@@ rtl/core/hre_distance.sv @@
// Offset to the destination, squares, sum and a pipelined integer square
// root with saturation. Depends on hre_pkg.
module hre_distance (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic             in_valid,
    input  hre_pkg::hre_div_t in_div,
    output logic             out_valid,
    output logic [23:0]      reproj_error,
    output logic             degenerate
);
    import hre_pkg::*;

    logic        d_valid_reg;
    logic        d_err_reg;
    logic [27:0] mx_reg;
    logic [27:0] my_reg;
    logic        d_err_next;
    logic [27:0] mx_next;
    logic [27:0] my_next;

    logic        q_valid_reg;
    logic        q_err_reg;
    logic [55:0] sqx_reg;
    logic [55:0] sqy_reg;

    logic      valid_reg  [ROOT_STEPS+1];
    hre_root_t root_reg   [ROOT_STEPS+1];
    hre_root_t root_next  [ROOT_STEPS+1];
    logic      sat;

    // Signed projected point minus destination, then magnitude
    always_comb
    begin
        logic signed [28:0] px;
        logic signed [28:0] py;
        logic signed [28:0] dx;
        logic signed [28:0] dy;
        px = in_div.neg_x ? -$signed({2'b0, in_div.qx}) : $signed({2'b0, in_div.qx});
        py = in_div.neg_y ? -$signed({2'b0, in_div.qy}) : $signed({2'b0, in_div.qy});
        dx = px - $signed({5'b0, in_div.dst_x});
        dy = py - $signed({5'b0, in_div.dst_y});
        mx_next = dx[28] ? 28'(-dx) : dx[27:0];
        my_next = dy[28] ? 28'(-dy) : dy[27:0];
        d_err_next = in_div.err
                     || (in_div.qx[QUOT_W-1] && (in_div.qx[QUOT_W-2:0] != '0))
                     || (in_div.qy[QUOT_W-1] && (in_div.qy[QUOT_W-2:0] != '0));
    end

    // Sum of squares enters the root pipeline; one root bit per stage
    always_comb
    begin
        logic [ROOT_W-1:0] bitv;
        logic [ROOT_W-1:0] t;
        root_next[0].err = q_err_reg;
        root_next[0].n   = ROOT_W'(sqx_reg) + ROOT_W'(sqy_reg);
        root_next[0].res = '0;
        for (int g = 0; g < ROOT_STEPS; g++)
        begin
            root_next[g+1] = root_reg[g];
            bitv = ROOT_W'(1) << (2 * (ROOT_STEPS - 1 - g));
            t    = root_reg[g].res + bitv;
            if (root_reg[g].n >= t)
            begin
                root_next[g+1].n   = root_reg[g].n - t;
                root_next[g+1].res = (root_reg[g].res >> 1) + bitv;
            end
            else
            begin
                root_next[g+1].res = root_reg[g].res >> 1;
            end
        end
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
            q_valid_reg <= 1'b0;
            for (int g = 0; g <= ROOT_STEPS; g++)
            begin
                valid_reg[g] <= 1'b0;
            end
        end
        else if (advance)
        begin
            d_valid_reg  <= in_valid;
            q_valid_reg  <= d_valid_reg;
            valid_reg[0] <= q_valid_reg;
            for (int g = 0; g < ROOT_STEPS; g++)
            begin
                valid_reg[g+1] <= valid_reg[g];
            end
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            d_err_reg <= d_err_next;
            mx_reg    <= mx_next;
            my_reg    <= my_next;
            q_err_reg <= d_err_reg;
            sqx_reg   <= {28'b0, mx_reg} * {28'b0, mx_reg};
            sqy_reg   <= {28'b0, my_reg} * {28'b0, my_reg};
            root_reg  <= root_next;
        end
    end

    // Saturate and flag
    assign sat          = root_reg[ROOT_STEPS].res[ROOT_W-1:24] != '0;
    assign out_valid    = valid_reg[ROOT_STEPS];
    assign degenerate   = root_reg[ROOT_STEPS].err || sat;
    assign reproj_error = degenerate ? ERR_MAX : root_reg[ROOT_STEPS].res[23:0];

endmodule

@@ tb/homography_reprojection_error_unit_tb.sv @@
// Self-checking bench for the homography reprojection error unit: a directed
// table, then random coefficient loads and point measures checked by a predictor.
// Depends on hre_pkg, hre_if and the unit itself.
module homography_reprojection_error_unit_tb;
    import hre_pkg::*;

    localparam int NUM_COEFFS   = NUM_HOMOGRAPHIES * COEFFS_PER_MATRIX;
    localparam int RANDOM_ITEMS = 900;
    localparam int CALM_FROM    = 800;
    localparam int HOLD_AT      = 450;
    localparam int DRAIN_CYCLES = 100;
    localparam int STALL_LIMIT  = 2000;

    typedef struct {
        logic               action;
        logic [5:0]         coeff_index;
        logic signed [47:0] coeff_value;
        logic [3:0]         pair_index;
        logic [23:0]        src_x;
        logic [23:0]        src_y;
        logic [23:0]        dst_x;
        logic [23:0]        dst_y;
    } beat_t;

    typedef struct {
        beat_t       b;
        bit          typed;
        logic [23:0] err;
        logic        deg;
    } row_t;

    typedef struct {
        logic [23:0] err;
        logic        deg;
    } distance_t;

    logic clk;
    logic rst_n;
    bit   calm;
    bit   failed;
    int   issued;

    hre_item_if   item_ch ();
    hre_result_if res_ch ();

    homography_reprojection_error_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch)
    );

    // Coefficient store as the unit should hold it, and distances awaited
    logic signed [47:0] coeff_store [NUM_COEFFS];
    distance_t          pending_distances [$];
    row_t               directed_rows [$];

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Signed random value in [-2^bits, 2^bits)
    function automatic logic signed [47:0] rnd_signed(input int bits);
        logic signed [47:0] r;
        r = 48'({$urandom, $urandom});
        return r >>> (47 - bits);
    endfunction

    // floor(c * v / 2^32), flagging anything outside signed 64 bits
    function automatic logic signed [63:0] mul_q32(input logic signed [47:0] c,
                                                   input logic signed [63:0] v,
                                                   inout bit ovf);
        logic signed [127:0] a;
        logic signed [127:0] b;
        logic signed [127:0] p;
        a = 128'(c);
        b = 128'(v);
        p = (a * b) >>> 32;
        if (p[127:63] != {65{1'b0}} && p[127:63] != {65{1'b1}})
            ovf = 1'b1;
        return p[63:0];
    endfunction

    function automatic logic signed [63:0] add_chk(input logic signed [63:0] a,
                                                   input logic signed [63:0] b,
                                                   inout bit ovf);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s[64] != s[63])
            ovf = 1'b1;
        return s[63:0];
    endfunction

    // Truncated quotient in Q.8; flag magnitudes above 2^26
    function automatic logic signed [63:0] div_q8(input logic signed [63:0] num,
                                                  input logic signed [63:0] den,
                                                  inout bit big);
        logic [127:0] nm;
        logic [127:0] dm;
        logic [127:0] q;
        nm = num < 0 ? 128'(-num) : 128'(num);
        dm = den < 0 ? 128'(-den) : 128'(den);
        nm[127:64] = '0;
        dm[127:64] = '0;
        q = (nm << 8) / dm;
        if (q > (128'd1 << 26))
        begin
            big = 1'b1;
            return 64'sd0;
        end
        return ((num < 0) != (den < 0)) ? -$signed(q[63:0]) : $signed(q[63:0]);
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] t;
        res = '0;
        for (int i = 31; i >= 0; i--)
        begin
            t = res | (64'd1 << i);
            if (t * t <= n)
                res = t;
        end
        return res;
    endfunction

    // Apply one beat to the store; return whether it yields a distance
    function automatic bit predict_distance(input beat_t b, output distance_t d);
        logic [2:0]         from_m;
        logic [2:0]         to_m;
        logic signed [63:0] vec [3];
        logic signed [63:0] nv [3];
        logic signed [63:0] acc;
        logic signed [63:0] px;
        logic signed [63:0] py;
        logic signed [63:0] ex;
        logic signed [63:0] ey;
        logic [63:0]        root_val;
        bit                 ovf;
        bit                 big;
        logic [5:0]         base;
        ovf = 1'b0;
        big = 1'b0;
        d.err = ERR_MAX;
        d.deg = 1'b1;
        if (b.action == ACTION_LOAD)
        begin
            if (b.coeff_index < NUM_COEFFS)
                coeff_store[b.coeff_index] = b.coeff_value;
            return 1'b0;
        end
        if (b.pair_index >= NUM_PAIRS)
            return 1'b0;
        case (b.pair_index)
            4'd0, 4'd1, 4'd2, 4'd3: from_m = 3'd0;
            4'd4, 4'd5, 4'd6:       from_m = 3'd1;
            4'd7, 4'd8:             from_m = 3'd2;
            default:                from_m = 3'd3;
        endcase
        case (b.pair_index)
            4'd0:                   to_m = 3'd1;
            4'd1, 4'd4:             to_m = 3'd2;
            4'd2, 4'd5, 4'd7:       to_m = 3'd3;
            default:                to_m = 3'd4;
        endcase
        if (to_m > NUM_HOMOGRAPHIES)
            return 1'b0;
        vec[0] = {16'd0, b.src_x, 24'd0};
        vec[1] = {16'd0, b.src_y, 24'd0};
        vec[2] = 64'sd1 << 32;
        for (int k = from_m; k < to_m; k++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                base = 6'(k * COEFFS_PER_MATRIX + r * 3);
                acc = mul_q32(coeff_store[base], vec[0], ovf);
                acc = add_chk(acc, mul_q32(coeff_store[base + 6'd1], vec[1], ovf), ovf);
                acc = add_chk(acc, mul_q32(coeff_store[base + 6'd2], vec[2], ovf), ovf);
                nv[r] = acc;
            end
            vec = nv;
        end
        if (ovf || vec[2] == 0)
            return 1'b1;
        px = div_q8(vec[0], vec[2], big);
        py = div_q8(vec[1], vec[2], big);
        if (big)
            return 1'b1;
        ex = px - $signed({40'd0, b.dst_x});
        ey = py - $signed({40'd0, b.dst_y});
        if (ex < 0)
            ex = -ex;
        if (ey < 0)
            ey = -ey;
        root_val = floor_sqrt(ex * ex + ey * ey);
        if (root_val <= 64'(ERR_MAX))
        begin
            d.err = root_val[23:0];
            d.deg = 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic beat_t load_beat(input int idx, input logic signed [47:0] val);
        beat_t b;
        b = '{default: '0};
        b.action = ACTION_LOAD;
        b.coeff_index = 6'(idx);
        b.coeff_value = val;
        return b;
    endfunction

    function automatic beat_t measure_beat(input int pair, input logic [23:0] sx,
                                           input logic [23:0] sy, input logic [23:0] ex,
                                           input logic [23:0] ey);
        beat_t b;
        b = '{default: '0};
        b.action = ACTION_MEASURE;
        b.pair_index = 4'(pair);
        b.src_x = sx;
        b.src_y = sy;
        b.dst_x = ex;
        b.dst_y = ey;
        return b;
    endfunction

    function automatic row_t row(input beat_t b, input bit typed = 1'b0,
                                 input logic [23:0] err = '0, input logic deg = 1'b0);
        row_t r;
        r.b = b;
        r.typed = typed;
        r.err = err;
        r.deg = deg;
        return r;
    endfunction

    // Present one beat, hold it until taken, then record what it should yield
    task automatic send(input beat_t b, input bit typed = 1'b0,
                        input logic [23:0] err = '0, input logic deg = 1'b0);
        distance_t d;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            item_ch.valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        item_ch.action      = b.action;
        item_ch.coeff_index = b.coeff_index;
        item_ch.coeff_value = b.coeff_value;
        item_ch.pair_index  = b.pair_index;
        item_ch.src_x       = b.src_x;
        item_ch.src_y       = b.src_y;
        item_ch.dst_x       = b.dst_x;
        item_ch.dst_y       = b.dst_y;
        item_ch.valid       = 1'b1;
        do @(posedge clk); while (!item_ch.ready);
        if (predict_distance(b, d))
        begin
            if (typed)
            begin
                d.err = err;
                d.deg = deg;
            end
            pending_distances.push_back(d);
        end
        issued++;
        @(negedge clk);
    endtask

    task automatic load_identity(input int m);
        for (int i = 0; i < COEFFS_PER_MATRIX; i++)
            send(load_beat(m * COEFFS_PER_MATRIX + i,
                           (i % 4 == 0) ? 48'sh0001_0000_0000 : 48'sh0));
    endtask

    // Near-identity matrix: small rotation, shift and perspective terms
    task automatic load_near_identity(input int m);
        logic signed [47:0] v;
        for (int i = 0; i < COEFFS_PER_MATRIX; i++)
        begin
            case (i)
                0, 4, 8: v = 48'sh0001_0000_0000 + rnd_signed(28);
                2, 5:    v = rnd_signed(40);
                6, 7:    v = rnd_signed(12);
                default: v = rnd_signed(28);
            endcase
            send(load_beat(m * COEFFS_PER_MATRIX + i, v));
        end
    endtask

    // Result side: random stall bursts, none once the run calms down
    initial
    begin
        int stall;
        res_ch.ready = 1'b0;
        stall = 0;
        forever
        begin
            @(negedge clk);
            if (calm)
                res_ch.ready = 1'b1;
            else if (stall > 0)
            begin
                res_ch.ready = 1'b0;
                stall--;
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                res_ch.ready = 1'b0;
                stall = $urandom_range(0, 5);
            end
            else
                res_ch.ready = 1'b1;
        end
    end

    // Compare each result beat with the oldest awaited distance
    always @(posedge clk)
    begin
        distance_t d;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_distances.size() == 0)
            begin
                $display("%0t: unexpected result err=%h deg=%b", $time,
                         res_ch.reproj_error, res_ch.degenerate);
                failed = 1'b1;
            end
            else
            begin
                d = pending_distances.pop_front();
                if (res_ch.reproj_error !== d.err)
                begin
                    $display("%0t: reproj_error expected %h actual %h", $time,
                             d.err, res_ch.reproj_error);
                    failed = 1'b1;
                end
                if (res_ch.degenerate !== d.deg)
                begin
                    $display("%0t: degenerate expected %b actual %b", $time,
                             d.deg, res_ch.degenerate);
                    failed = 1'b1;
                end
            end
        end
    end

    // Watchdog: end the run when neither channel moves for too long
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("FAIL homography_reprojection_error_unit");
                $finish;
            end
        end
    end

    // Stimulus
    initial
    begin
        int seq_len;
        calm = 1'b0;
        issued = 0;
        rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.action = ACTION_LOAD;
        item_ch.coeff_index = '0;
        item_ch.coeff_value = '0;
        item_ch.pair_index = '0;
        item_ch.src_x = '0;
        item_ch.src_y = '0;
        item_ch.dst_x = '0;
        item_ch.dst_y = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Every coefficient written before anything is measured
        for (int m = 0; m < NUM_HOMOGRAPHIES; m++)
            load_identity(m);

        // Directed table
        directed_rows.push_back(row(measure_beat(0, 24'd0, 24'd0, 24'd0, 24'd0),
                                    1'b1, 24'd0, 1'b0));
        directed_rows.push_back(row(measure_beat(9, 24'hFF_FFFF, 24'hFF_FFFF,
                                                 24'hFF_FFFF, 24'hFF_FFFF),
                                    1'b1, 24'd0, 1'b0));
        directed_rows.push_back(row(measure_beat(3, 24'h300, 24'h400, 24'd0, 24'd0),
                                    1'b1, 24'h500, 1'b0));
        directed_rows.push_back(row(measure_beat(6, 24'hFF_FFFF, 24'hFF_FFFF,
                                                 24'd0, 24'd0),
                                    1'b1, ERR_MAX, 1'b1));
        directed_rows.push_back(row(measure_beat(10, 24'h100, 24'h100, 24'd0, 24'd0)));
        directed_rows.push_back(row(measure_beat(15, 24'h100, 24'h100, 24'd0, 24'd0)));
        directed_rows.push_back(row(load_beat(36, 48'sh7FFF_FFFF_FFFF)));
        directed_rows.push_back(row(load_beat(63, -48'sh8000_0000_0000)));
        directed_rows.push_back(row(measure_beat(5, 24'h1234, 24'h5678, 24'h1234, 24'h5678),
                                    1'b1, 24'd0, 1'b0));
        // Zero bottom row in the last matrix: w vanishes
        directed_rows.push_back(row(load_beat(35, 48'sh0)));
        directed_rows.push_back(row(measure_beat(9, 24'h100, 24'h200, 24'd0, 24'd0),
                                    1'b1, ERR_MAX, 1'b1));
        directed_rows.push_back(row(load_beat(35, 48'sh0001_0000_0000)));
        // Extreme coefficients: overflow and out-of-range quotients
        directed_rows.push_back(row(load_beat(0, 48'sh7FFF_FFFF_FFFF)));
        directed_rows.push_back(row(measure_beat(0, 24'hFF_FFFF, 24'h0, 24'd0, 24'd0)));
        directed_rows.push_back(row(load_beat(1, -48'sh8000_0000_0000)));
        directed_rows.push_back(row(measure_beat(0, 24'hFF_FFFF, 24'hFF_FFFF, 24'd0, 24'd0)));
        directed_rows.push_back(row(load_beat(8, 48'sh0000_0000_0001)));
        directed_rows.push_back(row(measure_beat(1, 24'h1, 24'h1, 24'h1, 24'h1)));
        directed_rows.push_back(row(load_beat(0, 48'sh0000_8000_0000)));
        directed_rows.push_back(row(load_beat(1, 48'sh0)));
        directed_rows.push_back(row(load_beat(8, 48'sh0001_0000_0000)));
        directed_rows.push_back(row(measure_beat(2, 24'h800, 24'h10, 24'h400, 24'h10),
                                    1'b1, 24'd0, 1'b0));
        foreach (directed_rows[i])
            send(directed_rows[i].b, directed_rows[i].typed,
                 directed_rows[i].err, directed_rows[i].deg);

        for (int m = 0; m < NUM_HOMOGRAPHIES; m++)
            load_identity(m);

        // Random part: mostly matrix reloads followed by measures, some noise
        issued = 0;
        while (issued < RANDOM_ITEMS)
        begin
            if (issued >= CALM_FROM)
                calm = 1'b1;
            if (issued >= HOLD_AT && issued < HOLD_AT + 30)
            begin
                item_ch.valid = 1'b0;
                while (pending_distances.size() != 0)
                    @(negedge clk);
                issued = HOLD_AT + 30;
            end
            if ($urandom_range(0, 7) != 0)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    for (int m = 0; m < NUM_HOMOGRAPHIES; m++)
                        load_near_identity(m);
                end
                else
                    load_near_identity($urandom_range(0, NUM_HOMOGRAPHIES - 1));
                seq_len = $urandom_range(5, 20);
                for (int i = 0; i < seq_len; i++)
                begin
                    beat_t b;
                    b = measure_beat($urandom_range(0, NUM_PAIRS - 1),
                                     24'($urandom_range(0, 24'hFF_FFFF)),
                                     24'($urandom_range(0, 24'hFF_FFFF)), 24'd0, 24'd0);
                    if ($urandom_range(0, 3) == 0)
                    begin
                        b.dst_x = 24'($urandom_range(0, 24'hFF_FFFF));
                        b.dst_y = 24'($urandom_range(0, 24'hFF_FFFF));
                    end
                    else
                    begin
                        b.dst_x = b.src_x ^ 24'($urandom_range(0, 16'hFFFF));
                        b.dst_y = b.src_y ^ 24'($urandom_range(0, 16'hFFFF));
                    end
                    send(b);
                end
            end
            else
            begin
                seq_len = $urandom_range(1, 6);
                for (int i = 0; i < seq_len; i++)
                begin
                    if ($urandom_range(0, 1) == 0)
                        send(load_beat($urandom_range(0, 63), rnd_signed(47)));
                    else
                        send(measure_beat($urandom_range(0, 15),
                                          24'($urandom_range(0, 24'hFF_FFFF)),
                                          24'($urandom_range(0, 24'hFF_FFFF)),
                                          24'($urandom_range(0, 24'hFF_FFFF)),
                                          24'($urandom_range(0, 24'hFF_FFFF))));
                end
            end
        end
        item_ch.valid = 1'b0;

        // Drain, then allow the pipeline depth for anything stray
        while (pending_distances.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (!failed)
            $display("PASS homography_reprojection_error_unit");
        else
            $display("FAIL homography_reprojection_error_unit");
        $finish;
    end

endmodule
